/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Simulation builds get the checks,
// synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define GDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define GDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/gdc_pkg.sv */
`timescale 1ns / 1ps

package gdc_pkg;

    // Fixed port widths of the streaming and configuration interfaces.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_DATA_W  = 4;
    localparam int LABEL_W     = 8;
    localparam int INDEX_W     = 2;

    // Input item kinds carried on tuser.
    typedef enum logic [1:0] {
        KIND_MEAN    = 2'd0,
        KIND_COV     = 2'd1,
        KIND_LABEL   = 2'd2,
        KIND_FEATURE = 2'd3
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_CLASSES  = 1'b0,
        CFG_FEATURES = 1'b1
    } t_cfg_reg;

    // Sequencer program addresses.
    typedef enum logic [3:0] {
        PC_IDLE,
        PC_INIT,
        PC_MAC,
        PC_DRAIN1,
        PC_DRAIN2,
        PC_MUL_LO,
        PC_MUL_HI,
        PC_ACC_WAIT,
        PC_COMPARE,
        PC_DONE
    } t_pc;

    // Jump conditions tested by a control word.
    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_START,
        C_COL_MORE,
        C_ROW_MORE,
        C_SLOT_MORE,
        C_OUT_BUSY
    } t_cond;

    // Multiplier use requested by a control word outside the MAC pipeline.
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI
    } t_mul;

    // Where a registered product is added.
    typedef enum logic [1:0] {
        DST_NONE,
        DST_T,
        DST_LO,
        DST_HI
    } t_dst;

    // One control word of the microprogram.
    typedef struct packed {
        logic  init;      // clear counters and accumulators
        logic  issue;     // issue a table read for one multiply-accumulate
        logic  row_adv;   // next matrix row, clear the row sum
        logic  slot_adv;  // compare the score and move to the next slot
        t_mul  mul;
        t_cond cond;
        t_pc   jmp;       // next step when the condition holds
        t_pc   nxt;       // next step otherwise
    } t_uword;

    // Microprogram ROM.
    function automatic t_uword f_ucode(input t_pc pc);
        t_uword w;
        begin
            w.init     = 1'b0;
            w.issue    = 1'b0;
            w.row_adv  = 1'b0;
            w.slot_adv = 1'b0;
            w.mul      = MUL_NONE;
            w.cond     = C_NEVER;
            w.jmp      = PC_IDLE;
            w.nxt      = PC_IDLE;
            unique case (pc)
                PC_IDLE: begin
                    w.cond = C_NO_START;
                    w.jmp  = PC_IDLE;
                    w.nxt  = PC_INIT;
                end
                PC_INIT: begin
                    w.init = 1'b1;
                    w.nxt  = PC_MAC;
                end
                PC_MAC: begin
                    w.issue = 1'b1;
                    w.cond  = C_COL_MORE;
                    w.jmp   = PC_MAC;
                    w.nxt   = PC_DRAIN1;
                end
                PC_DRAIN1: begin
                    w.nxt = PC_DRAIN2;
                end
                PC_DRAIN2: begin
                    w.nxt = PC_MUL_LO;
                end
                PC_MUL_LO: begin
                    w.mul = MUL_LO;
                    w.nxt = PC_MUL_HI;
                end
                PC_MUL_HI: begin
                    w.mul     = MUL_HI;
                    w.row_adv = 1'b1;
                    w.cond    = C_ROW_MORE;
                    w.jmp     = PC_MAC;
                    w.nxt     = PC_ACC_WAIT;
                end
                PC_ACC_WAIT: begin
                    w.nxt = PC_COMPARE;
                end
                PC_COMPARE: begin
                    w.slot_adv = 1'b1;
                    w.cond     = C_SLOT_MORE;
                    w.jmp      = PC_MAC;
                    w.nxt      = PC_DONE;
                end
                PC_DONE: begin
                    w.cond = C_OUT_BUSY;
                    w.jmp  = PC_DONE;
                    w.nxt  = PC_IDLE;
                end
                default: begin
                    w.nxt = PC_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/gaussian_discriminant_classifier_unit.sv */
`timescale 1ns / 1ps
// Channel   | Direction | tdata (low bit up)                         | tuser | Handshake
// ----------+-----------+--------------------------------------------+-------+-------------
// s_axis    | in        | class_slot[1:0] row[4:2] col[7:5]          | kind  | tvalid/tready
//           |           | value[23:8]                                |       |
// m_axis    | out       | class_label[7:0] class_index[9:8] zero pad | -     | tvalid/tready
// cfg       | in        | i_cfg_index selects, i_cfg_data writes     | -     | i_cfg_we
//
// Load items and feature items that are not the last row are taken one per cycle while idle.
// The last feature row starts the microprogram, which is busy while it runs every slot
// through the single shared multiplier, one product per cycle.
// Reset is synchronous and clears control state only; the tables need no clearing pass.
// A finished result waits in the output register while new items are accepted;
// the sequencer holds its last step only if the next result finds it still full.
`include "assert_macros.svh"

module gaussian_discriminant_classifier_unit #(
    parameter int NUM_CLASSES  = 4,
    parameter int NUM_FEATURES = 8,
    parameter int VALUE_BITS   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // class_slot[1:0], row[4:2], col[7:5], value[23:8]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                         s_axis_tuser,
    // class_label[7:0], class_index[9:8], zero padding above
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [gdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int KW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int FW   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int MD   = NUM_CLASSES * NUM_FEATURES;
    localparam int CD   = MD * NUM_FEATURES;
    localparam int MAW  = (MD > 1) ? $clog2(MD) : 1;
    localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
    localparam int VB   = VALUE_BITS;
    localparam int DW   = VB + 2;
    localparam int TW   = 2 * VB + $clog2(NUM_FEATURES) + 1;
    localparam int LH   = TW / 2;
    localparam int HW   = TW - LH;
    localparam int OB0  = (VB > LH + 1) ? VB : LH + 1;
    localparam int OB   = (OB0 > HW) ? OB0 : HW;
    localparam int PW   = DW + OB;
    localparam int ACCW = DW + TW + $clog2(NUM_FEATURES) + 1;
    localparam int PADW = gdc_pkg::OUT_TDATA_W - gdc_pkg::LABEL_W - gdc_pkg::INDEX_W;

    // Input unpacking.
    gdc_pkg::t_kind        w_kind;
    logic [1:0]            w_slot;
    logic [2:0]            w_row;
    logic [2:0]            w_col;
    logic signed [15:0]    w_value;
    logic signed [VB-1:0]  w_stored;
    logic                  w_slot_ok;
    logic                  w_row_ok;
    logic                  w_col_ok;
    logic                  w_acc_in;
    logic                  w_start;

    assign w_kind    = gdc_pkg::t_kind'(s_axis_tuser);
    assign w_slot    = s_axis_tdata[1:0];
    assign w_row     = s_axis_tdata[4:2];
    assign w_col     = s_axis_tdata[7:5];
    assign w_value   = s_axis_tdata[23:8];
    assign w_stored  = VB'(w_value);
    assign w_slot_ok = int'(w_slot) < NUM_CLASSES;
    assign w_row_ok  = int'(w_row) < NUM_FEATURES;
    assign w_col_ok  = int'(w_col) < NUM_FEATURES;
    assign w_acc_in  = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    logic [2:0] r_cfg_classes;
    logic [3:0] r_cfg_features;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_classes  <= 3'd1;
            r_cfg_features <= 4'd8;
        end else if (i_cfg_we) begin
            if (i_cfg_index == gdc_pkg::CFG_CLASSES) begin
                r_cfg_classes <= i_cfg_data[2:0];
            end else begin
                r_cfg_features <= i_cfg_data;
            end
        end
    end

    // Last slot and last row in use, with out-of-range settings clamped.
    logic [KW-1:0] w_k_last;
    logic [FW-1:0] w_f_last;

    always_comb begin
        if (r_cfg_classes == 3'd0) begin
            w_k_last = '0;
        end else if (int'(r_cfg_classes) > NUM_CLASSES) begin
            w_k_last = KW'(NUM_CLASSES - 1);
        end else begin
            w_k_last = KW'(int'(r_cfg_classes) - 1);
        end
        if (r_cfg_features == 4'd0) begin
            w_f_last = '0;
        end else if (int'(r_cfg_features) > NUM_FEATURES) begin
            w_f_last = FW'(NUM_FEATURES - 1);
        end else begin
            w_f_last = FW'(int'(r_cfg_features) - 1);
        end
    end

    // The last feature row starts a classification.
    assign w_start = w_acc_in && (w_kind == gdc_pkg::KIND_FEATURE) && w_row_ok &&
                     (int'(w_row) == int'(w_f_last));

    // Sequencer counters.
    logic [KW-1:0] r_k;
    logic [FW-1:0] r_i;
    logic [FW-1:0] r_j;

    // Model tables.
    logic             w_mean_we;
    logic             w_cov_we;
    logic [MAW-1:0]   w_mean_waddr;
    logic [CAW-1:0]   w_cov_waddr;
    logic [MAW-1:0]   w_mean_raddr;
    logic [CAW-1:0]   w_cov_raddr;
    logic [VB-1:0]    w_mean_rdata;
    logic [VB-1:0]    w_cov_rdata;

    assign w_mean_we    = w_acc_in && (w_kind == gdc_pkg::KIND_MEAN) && w_slot_ok && w_row_ok;
    assign w_cov_we     = w_acc_in && (w_kind == gdc_pkg::KIND_COV) && w_slot_ok && w_row_ok &&
                          w_col_ok;
    assign w_mean_waddr = MAW'(int'(w_slot) * NUM_FEATURES + int'(w_row));
    assign w_cov_waddr  = CAW'((int'(w_slot) * NUM_FEATURES + int'(w_row)) * NUM_FEATURES +
                               int'(w_col));
    assign w_mean_raddr = MAW'(int'(r_k) * NUM_FEATURES + int'(r_j));
    assign w_cov_raddr  = CAW'((int'(r_k) * NUM_FEATURES + int'(r_i)) * NUM_FEATURES +
                               int'(r_j));

    gdc_ram #(
        .WIDTH (VB),
        .DEPTH (MD)
    ) u_mean_ram (
        .i_clk   (i_clk),
        .i_we    (w_mean_we),
        .i_waddr (w_mean_waddr),
        .i_wdata (w_stored),
        .i_raddr (w_mean_raddr),
        .o_rdata (w_mean_rdata)
    );

    gdc_ram #(
        .WIDTH (VB),
        .DEPTH (CD)
    ) u_cov_ram (
        .i_clk   (i_clk),
        .i_we    (w_cov_we),
        .i_waddr (w_cov_waddr),
        .i_wdata (w_stored),
        .i_raddr (w_cov_raddr),
        .o_rdata (w_cov_rdata)
    );

    // Labels and the feature vector live in flops.
    logic [gdc_pkg::LABEL_W-1:0] r_label [NUM_CLASSES];
    logic signed [VB-1:0]        r_feat [NUM_FEATURES];

    always_ff @(posedge i_clk) begin
        if (w_acc_in && (w_kind == gdc_pkg::KIND_LABEL) && w_slot_ok) begin
            r_label[KW'(w_slot)] <= w_value[7:0];
        end
        if (w_acc_in && (w_kind == gdc_pkg::KIND_FEATURE) && w_row_ok) begin
            r_feat[FW'(w_row)] <= w_stored;
        end
    end

    // Program counter and control word decode.
    gdc_pkg::t_pc    r_pc;
    gdc_pkg::t_pc    n_pc;
    gdc_pkg::t_uword w_uw;
    logic            w_hit;
    logic            r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= gdc_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        w_uw = gdc_pkg::f_ucode(r_pc);
        unique case (w_uw.cond)
            gdc_pkg::C_NEVER:     w_hit = 1'b0;
            gdc_pkg::C_NO_START:  w_hit = !w_start;
            gdc_pkg::C_COL_MORE:  w_hit = (r_j != w_f_last);
            gdc_pkg::C_ROW_MORE:  w_hit = (r_i != w_f_last);
            gdc_pkg::C_SLOT_MORE: w_hit = (r_k != w_k_last);
            gdc_pkg::C_OUT_BUSY:  w_hit = r_out_vld && !m_axis_tready;
            default:              w_hit = 1'b0;
        endcase
        n_pc = w_hit ? w_uw.jmp : w_uw.nxt;
    end

    assign s_axis_tready = (r_pc == gdc_pkg::PC_IDLE);

    // Slot, row and column counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_uw.init) begin
            r_k <= '0;
            r_i <= '0;
            r_j <= '0;
        end else begin
            if (w_uw.issue) begin
                r_j <= r_j + 1'b1;
            end
            if (w_uw.row_adv) begin
                r_i <= r_i + 1'b1;
                r_j <= '0;
            end
            if (w_uw.slot_adv) begin
                r_k <= r_k + 1'b1;
                r_i <= '0;
                r_j <= '0;
            end
        end
    end

    // Read stage: table data arrives in the cycle after the read is issued.
    logic                 r_s1_vld;
    logic                 r_s1_cap;
    logic signed [VB-1:0] r_mi;
    logic signed [VB-1:0] w_c_rd;
    logic signed [VB-1:0] w_m_rd;

    assign w_c_rd = $signed(w_cov_rdata);
    assign w_m_rd = $signed(w_mean_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_uw.issue;
        end
        r_s1_cap <= (r_j == r_i);
        // The diagonal read also delivers the mean element of the current row.
        if (r_s1_vld && r_s1_cap) begin
            r_mi <= w_m_rd;
        end
    end

    // Shared multiplier: C*m inside the row loop, then (2x - m) times the row sum.
    logic signed [TW-1:0]   r_t;
    logic signed [ACCW-1:0] r_acc;
    logic signed [VB-1:0]   w_x;
    logic signed [DW-1:0]   w_d;
    logic signed [DW-1:0]   w_ma;
    logic signed [OB-1:0]   w_mb;
    logic signed [PW-1:0]   w_prod;
    gdc_pkg::t_dst          w_dst;
    logic signed [PW-1:0]   r_prod;
    gdc_pkg::t_dst          r_pdst;

    assign w_x = r_feat[r_i];
    assign w_d = (DW'(w_x) <<< 1) - DW'(r_mi);

    always_comb begin
        if (r_s1_vld) begin
            w_ma  = DW'(w_c_rd);
            w_mb  = OB'(w_m_rd);
            w_dst = gdc_pkg::DST_T;
        end else begin
            w_ma = w_d;
            if (w_uw.mul == gdc_pkg::MUL_HI) begin
                w_mb  = OB'($signed(r_t[TW-1:LH]));
                w_dst = gdc_pkg::DST_HI;
            end else begin
                w_mb  = OB'($signed({1'b0, r_t[LH-1:0]}));
                w_dst = (w_uw.mul == gdc_pkg::MUL_LO) ? gdc_pkg::DST_LO : gdc_pkg::DST_NONE;
            end
        end
        w_prod = w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pdst <= gdc_pkg::DST_NONE;
        end else begin
            r_pdst <= w_dst;
        end
        r_prod <= w_prod;
    end

    // Accumulate stage: row sum and slot score.
    always_ff @(posedge i_clk) begin
        if (w_uw.init || w_uw.row_adv || w_uw.slot_adv) begin
            r_t <= '0;
        end else if (r_pdst == gdc_pkg::DST_T) begin
            r_t <= r_t + TW'(r_prod);
        end
        if (w_uw.init || w_uw.slot_adv) begin
            r_acc <= '0;
        end else begin
            case (r_pdst)
                gdc_pkg::DST_LO: r_acc <= r_acc + ACCW'(r_prod);
                gdc_pkg::DST_HI: r_acc <= r_acc + (ACCW'(r_prod) <<< LH);
                default:         r_acc <= r_acc;
            endcase
        end
    end

    // Best score so far; the first slot always takes it, later ones only if strictly higher.
    logic signed [ACCW-1:0] r_best;
    logic [KW-1:0]          r_best_k;

    always_ff @(posedge i_clk) begin
        if (w_uw.slot_adv && ((r_k == '0) || (r_acc > r_best))) begin
            r_best   <= r_acc;
            r_best_k <= r_k;
        end
    end

    // Output register.
    logic                        w_out_load;
    logic [gdc_pkg::LABEL_W-1:0] r_out_label;
    logic [gdc_pkg::INDEX_W-1:0] r_out_index;

    assign w_out_load = (r_pc == gdc_pkg::PC_DONE) && !(r_out_vld && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (w_out_load) begin
            r_out_label <= r_label[r_best_k];
            r_out_index <= gdc_pkg::INDEX_W'(r_best_k);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {PADW'(0), r_out_index, r_out_label};

    // The MAC pipeline and the score multiplies never share the multiplier.
    `GDC_ASSERT_IMP(a_mul_no_overlap, i_clk, i_rst_n, r_s1_vld, w_uw.mul == gdc_pkg::MUL_NONE)
    // The row sum is complete before its product with (2x - m) starts.
    `GDC_ASSERT_IMP(a_row_drained, i_clk, i_rst_n, r_pc == gdc_pkg::PC_MUL_LO, (r_pdst == gdc_pkg::DST_NONE) && !r_s1_vld)
    // The slot score is complete when it is compared.
    `GDC_ASSERT_IMP(a_score_drained, i_clk, i_rst_n, r_pc == gdc_pkg::PC_COMPARE, (r_pdst == gdc_pkg::DST_NONE) && !r_s1_vld)
    // The low partial product is followed by the high one.
    `GDC_ASSERT_NXT(a_lo_then_hi, i_clk, i_rst_n, r_pc == gdc_pkg::PC_MUL_LO, (r_pdst == gdc_pkg::DST_LO) && (r_pc == gdc_pkg::PC_MUL_HI))

endmodule

/* rtl/gdc_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module gdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
